[design/pp_steer_pkg.sv]
// ----------------------------------------------------------------------------
// Pure pursuit steering package
// Widths, constants and types shared by the pure pursuit steering command.
// ----------------------------------------------------------------------------
package pp_steer_pkg;

  localparam int COORD_W   = 20;
  localparam int FRAC_BITS = 12;
  localparam int LOOK_W    = COORD_W - 1;
  localparam int SPEED_W   = 16;
  localparam int THR_W     = 23;
  localparam int K_W       = 24;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 2;

  // Shared multiplier: the wide operand takes the threshold, the narrow one
  // the desired speed; both take the coordinates and the lookahead.
  localparam int MUL_A_W = K_W;
  localparam int MUL_B_W = COORD_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Shared restoring divider.
  localparam int SQ_W   = 2 * COORD_W;               // squared length
  localparam int DIV_W  = SQ_W;                      // divisor and remainder
  localparam int NUM_W  = COORD_W + 2 * FRAC_BITS + 1;
  localparam int Q_W    = K_W + 1;
  localparam int CNT_W  = $clog2(NUM_W);

  localparam logic [CNT_W-1:0] K_STEPS = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] S_STEPS = CNT_W'(SPEED_W - 1);

  localparam longint unsigned TINY_LEN2_L =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000;
  localparam logic [SQ_W-1:0] TINY_LEN2 = SQ_W'(TINY_LEN2_L);

  localparam logic [K_W-1:0] K_POS_MAX = {1'b0, {(K_W-1){1'b1}}};
  localparam logic [K_W-1:0] K_NEG_MAX = {1'b1, {(K_W-1){1'b0}}};

  localparam logic [LOOK_W-1:0]  LOOK_RESET    = LOOK_W'(4096);
  localparam logic [SPEED_W-1:0] DESIRED_RESET = SPEED_W'(2048);

  localparam int IN_DATA_W  = 2 * COORD_W;
  localparam int OUT_DATA_W = 2 * COORD_W + K_W + SPEED_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOKAHEAD   = 2'd0,
    CFG_DESIRED     = 2'd1,
    CFG_THRESHOLD   = 2'd2,
    CFG_SPEED_FLOOR = 2'd3
  } cfg_idx_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_SQX    = 10'b00_0000_0010,
    ST_SQY    = 10'b00_0000_0100,
    ST_SQL    = 10'b00_0000_1000,
    ST_DECIDE = 10'b00_0001_0000,
    ST_KDIV   = 10'b00_0010_0000,
    ST_KSAT   = 10'b00_0100_0000,
    ST_SMUL   = 10'b00_1000_0000,
    ST_SDIV   = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_t;

  // Magnitude of a two's complement coordinate; the most negative value maps
  // to its true magnitude, which still fits the unsigned width.
  function automatic logic [COORD_W-1:0] coord_mag(input logic [COORD_W-1:0] v);
    coord_mag = v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
  endfunction

endpackage

[design/pure_pursuit_steering_command.sv]
// ----------------------------------------------------------------------------
// Pure pursuit steering command
// Scans a stream of robot-frame path points for the carrot and emits its
// curvature and a regulated linear speed once per path.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  -------  ---------  -----------------------------------------------------
//  s_*      in         tdata: point_x[19:0], point_y[39:20]; tlast: last_of_path
//  m_*      out        tdata: carrot_x, carrot_y, curvature, linear_speed;
//                      tuser: used_fallback
//  cfg_*    in         write enable, register index, write data
//
//  A point after the carrot is only accepted and dropped. A point that does
//  not reach the lookahead radius passes through the shared multiplier.
//  The carrot also passes through the shared restoring divider: 45 steps
//  for the curvature and, when the speed is reduced, 16 for the reduced
//  speed.
//  Reset restores the register defaults and clears the carrot flag.
//  A finished result waits in the output register while the next point
//  is scanned; only the final load waits for m_tready.
//
module pure_pursuit_steering_command
  import pp_steer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y
  input  logic                  s_tlast,   // last_of_path
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // carrot_x, carrot_y, curvature, linear_speed
  output logic                  m_tuser,   // used_fallback
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  state_t state;

  logic [LOOK_W-1:0]  lookahead;
  logic [SPEED_W-1:0] desired;
  logic [THR_W-1:0]   threshold;
  logic [SPEED_W-1:0] speed_floor;
  logic               carrot_found;

  logic [COORD_W-1:0] px, py, ax, ay;
  logic               ny, plast, fallback, kzero, slow;
  logic [SQ_W-1:0]    sq_acc, sq_len, look_sq;
  logic [K_W-1:0]     kmag;

  logic [DIV_W-1:0]   rem, divisor;
  logic [NUM_W-1:0]   num;
  logic [Q_W-1:0]     quo;
  logic               quo_ovf;
  logic [CNT_W-1:0]   cnt;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic [DIV_W-1:0]   rem_sh;
  logic [DIV_W:0]     diff;
  logic               div_ge;

  logic               accept, out_free, slow_next;
  logic [K_W-1:0]     k_limit, kbits;
  logic [SPEED_W-1:0] floor_v, speed_v;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQX:  begin mul_a = MUL_A_W'(ax);        mul_b = ax;                 end
      ST_SQY:  begin mul_a = MUL_A_W'(ay);        mul_b = ay;                 end
      ST_SQL:  begin mul_a = MUL_A_W'(lookahead); mul_b = MUL_B_W'(lookahead); end
      ST_SMUL: begin mul_a = MUL_A_W'(threshold); mul_b = MUL_B_W'(desired);  end
      default: begin mul_a = '0;                  mul_b = '0;                 end
    endcase
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // One restoring division step.
  assign rem_sh = {rem[DIV_W-2:0], num[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, divisor};
  assign div_ge = !diff[DIV_W];

  assign k_limit   = ny ? K_NEG_MAX : K_POS_MAX;
  assign kbits     = ny ? (~kmag + K_W'(1)) : kmag;
  assign slow_next = (threshold != '0) && (kmag > K_W'(threshold));

  always_comb begin
    floor_v = (speed_floor < desired) ? speed_floor : desired;
    speed_v = desired;
    if (slow) begin
      speed_v = quo[SPEED_W-1:0];
      if (speed_v < floor_v) begin
        speed_v = floor_v;
      end
      if (speed_v > desired) begin
        speed_v = desired;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead   <= LOOK_RESET;
      desired     <= DESIRED_RESET;
      threshold   <= '0;
      speed_floor <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LOOKAHEAD:   lookahead   <= cfg_data[LOOK_W-1:0];
        CFG_DESIRED:     desired     <= cfg_data[SPEED_W-1:0];
        CFG_THRESHOLD:   threshold   <= cfg_data[THR_W-1:0];
        CFG_SPEED_FLOOR: speed_floor <= cfg_data[SPEED_W-1:0];
        default:         lookahead   <= lookahead;
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      carrot_found <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if ((state == ST_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (carrot_found) begin
              if (s_tlast) begin
                carrot_found <= 1'b0;
              end
            end else begin
              state <= ST_SQX;
            end
          end
        end
        ST_SQX:    state <= ST_SQY;
        ST_SQY:    state <= ST_SQL;
        ST_SQL:    state <= ST_DECIDE;
        ST_DECIDE: begin
          if (sq_len >= look_sq) begin
            carrot_found <= !plast;
            state        <= ST_KDIV;
          end else if (plast) begin
            carrot_found <= 1'b0;
            state        <= ST_KDIV;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_KDIV: begin
          if (cnt == '0) begin
            state <= ST_KSAT;
          end
        end
        ST_KSAT: state <= ST_SMUL;
        ST_SMUL: state <= slow_next ? ST_SDIV : ST_OUT;
        ST_SDIV: begin
          if (cnt == '0) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state) inside
      ST_IDLE: begin
        if (accept) begin
          px    <= s_tdata[COORD_W-1:0];
          py    <= s_tdata[2*COORD_W-1:COORD_W];
          ax    <= coord_mag(s_tdata[COORD_W-1:0]);
          ay    <= coord_mag(s_tdata[2*COORD_W-1:COORD_W]);
          ny    <= s_tdata[2*COORD_W-1];
          plast <= s_tlast;
        end
      end
      ST_SQX: sq_acc  <= prod[SQ_W-1:0];
      ST_SQY: sq_len  <= sq_acc + prod[SQ_W-1:0];
      ST_SQL: look_sq <= prod[SQ_W-1:0];
      ST_DECIDE: begin
        fallback <= !(sq_len >= look_sq);
        kzero    <= (sq_len < TINY_LEN2) || (ay == '0);
        rem      <= '0;
        divisor  <= sq_len;
        num      <= {ay, (NUM_W-COORD_W)'(0)};
        quo      <= '0;
        quo_ovf  <= 1'b0;
        cnt      <= K_STEPS;
      end
      ST_KDIV, ST_SDIV: begin
        rem     <= div_ge ? diff[DIV_W-1:0] : rem_sh;
        num     <= {num[NUM_W-2:0], 1'b0};
        quo     <= {quo[Q_W-2:0], div_ge};
        quo_ovf <= quo_ovf | quo[Q_W-1];
        cnt     <= cnt - CNT_W'(1);
      end
      ST_KSAT: begin
        // The quotient is only meaningful up to the saturation limit.
        if (kzero) begin
          kmag <= '0;
        end else if (quo_ovf || (quo > Q_W'(k_limit))) begin
          kmag <= k_limit;
        end else begin
          kmag <= quo[K_W-1:0];
        end
      end
      ST_SMUL: begin
        // Reduced speed is below desired, so the first 16 quotient bits suffice.
        slow    <= slow_next;
        rem     <= DIV_W'(prod[PROD_W-1:SPEED_W]);
        divisor <= DIV_W'(kmag);
        num     <= {prod[SPEED_W-1:0], (NUM_W-SPEED_W)'(0)};
        quo     <= '0;
        quo_ovf <= 1'b0;
        cnt     <= S_STEPS;
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= {speed_v, kbits, py, px};
          m_tuser <= fallback;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

[dv/tb_pure_pursuit_steering_command.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pure pursuit steering command testbench
// Streams robot-frame paths into the block and checks each carrot result
// against an in-bench copy of the carrot search, curvature and speed law.
// A short table of hand-picked points and register writes runs first, then
// random paths under several register settings and handshake idle patterns.
// ----------------------------------------------------------------------------
module tb_pure_pursuit_steering_command;
  import pp_steer_pkg::*;

  localparam int          ITEMS_PER_PHASE = 205;
  localparam int          RAND_PHASES     = 9;
  localparam int          SETTLE_CYCLES   = 16;
  localparam int          DIR_ROWS        = 32;
  localparam longint      TINY_S          = 17;          // ceil(1e-6 * 2^24)
  localparam longint      K_POS_LIM       = 64'd8388607;
  localparam longint      K_NEG_LIM       = 64'd8388608;

  typedef struct packed {
    logic [19:0] cx;
    logic [19:0] cy;
    logic [23:0] k;
    logic [15:0] spd;
    logic        fb;
  } steer_res_t;

  typedef enum logic [1:0] {ROW_POINT, ROW_KNOWN, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [22:0] wdata;
    logic [19:0] x;
    logic [19:0] y;
    logic        last;
    steer_res_t  res;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // point_x, point_y
  logic                  s_tlast = 1'b0; // last_of_path
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // carrot_x, carrot_y, curvature, linear_speed
  logic                  m_tuser;        // used_fallback
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_LOOKAHEAD;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Mirror of the block's registers and carrot flag.
  logic [18:0] la_dist   = 19'd4096;
  logic [15:0] v_desired = 16'd2048;
  logic [22:0] k_thresh  = 23'd0;
  logic [15:0] v_min     = 16'd0;
  bit          carrot_found = 1'b0;

  steer_res_t carrot_q[$];
  int fail_count   = 0;
  int points_sent  = 0;
  int paths_sent   = 0;
  int carrots_seen = 0;
  int fallbacks    = 0;
  int slowed       = 0;
  int settings     = 0;
  int tx_idle_pct  = 6;
  int rx_stall_pct = 60;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_KNOWN, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'd0, 1'b1,
      '{20'd0, 20'd0, 24'd0, 16'd2048, 1'b1}},
    '{ROW_KNOWN, CFG_LOOKAHEAD, 23'd0, 20'd4096, 20'd0, 1'b0,
      '{20'd4096, 20'd0, 24'd0, 16'd2048, 1'b0}},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'd1, 20'd1, 1'b0, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'd5, 20'd5, 1'b1, '0},
    '{ROW_KNOWN, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'd4096, 1'b1,
      '{20'd0, 20'd4096, 24'd8192, 16'd2048, 1'b0}},
    '{ROW_KNOWN, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'hFF000, 1'b1,
      '{20'd0, 20'hFF000, 24'hFFE000, 16'd2048, 1'b0}},
    '{ROW_KNOWN, CFG_LOOKAHEAD, 23'd0, 20'd3, 20'd2, 1'b1,
      '{20'd3, 20'd2, 24'd0, 16'd2048, 1'b1}},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'd100, 20'd3, 1'b0, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'hFFFF6, 20'd1, 1'b1, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'h80000, 20'h80000, 1'b1, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'h7FFFF, 20'h7FFFF, 1'b0, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'd0, 1'b1, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'h80000, 20'h7FFFF, 1'b1, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'h7FFFF, 20'hFFFFF, 1'b1, '0},
    '{ROW_CFG, CFG_THRESHOLD, 23'd4096, 20'd0, 20'd0, 1'b0, '0},
    '{ROW_CFG, CFG_SPEED_FLOOR, 23'd1024, 20'd0, 20'd0, 1'b0, '0},
    '{ROW_KNOWN, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'd4096, 1'b1,
      '{20'd0, 20'd4096, 24'd8192, 16'd1024, 1'b0}},
    '{ROW_KNOWN, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'd2048, 1'b1,
      '{20'd0, 20'd2048, 24'd16384, 16'd1024, 1'b1}},
    // A floor above the desired speed is cut back to the desired speed.
    '{ROW_CFG, CFG_SPEED_FLOOR, 23'd4000, 20'd0, 20'd0, 1'b0, '0},
    '{ROW_KNOWN, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'd2048, 1'b1,
      '{20'd0, 20'd2048, 24'd16384, 16'd2048, 1'b1}},
    '{ROW_CFG, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'd0, 1'b0, '0},
    '{ROW_CFG, CFG_DESIRED, 23'd65535, 20'd0, 20'd0, 1'b0, '0},
    '{ROW_CFG, CFG_THRESHOLD, 23'h7FFFFF, 20'd0, 20'd0, 1'b0, '0},
    '{ROW_CFG, CFG_SPEED_FLOOR, 23'd65535, 20'd0, 20'd0, 1'b0, '0},
    '{ROW_KNOWN, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'd0, 1'b0,
      '{20'd0, 20'd0, 24'd0, 16'd65535, 1'b0}},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'd7, 20'd7, 1'b1, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'd0, 20'hFF448, 1'b1, '0},
    '{ROW_CFG, CFG_LOOKAHEAD, 23'h7FFFF, 20'd0, 20'd0, 1'b0, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'h80000, 20'h80000, 1'b0, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'd1, 20'd2, 1'b1, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'h7FFFF, 20'd0, 1'b1, '0},
    '{ROW_POINT, CFG_LOOKAHEAD, 23'd0, 20'h7FFFE, 20'd0, 1'b1, '0}
  };

  pure_pursuit_steering_command DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the carrot search by one point; returns 1 when the point yields
  // a carrot, with the expected steering command in cmd.
  function automatic bit next_carrot(input logic [19:0] px, input logic [19:0] py,
                                     input logic plast, output steer_res_t cmd);
    logic [19:0] ax, ay;
    longint unsigned s, q, kmag, spd, flo;
    bit hit;
    cmd = '0;
    if (carrot_found) begin
      if (plast) carrot_found = 1'b0;
      return 1'b0;
    end
    ax  = px[19] ? 20'(-px) : px;
    ay  = py[19] ? 20'(-py) : py;
    s   = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
    hit = s >= 64'(la_dist) * 64'(la_dist);
    if (!hit && !plast) return 1'b0;
    kmag = 0;
    // Tiny carrots and carrots on the axis steer straight.
    if (s >= TINY_S && ay != 0) begin
      q = (64'(ay) << (2 * FRAC_BITS + 1)) / s;
      if (py[19]) begin
        kmag  = (q > K_NEG_LIM) ? K_NEG_LIM : q;
        cmd.k = 24'(~kmag + 1);
      end else begin
        kmag  = (q > K_POS_LIM) ? K_POS_LIM : q;
        cmd.k = kmag[23:0];
      end
    end
    spd = v_desired;
    if (k_thresh != 0 && kmag > k_thresh) begin
      flo = (v_min < v_desired) ? v_min : v_desired;
      spd = 64'(v_desired) * 64'(k_thresh) / kmag;
      if (spd < flo) spd = flo;
      if (spd > v_desired) spd = v_desired;
      slowed++;
    end
    cmd.cx  = px;
    cmd.cy  = py;
    cmd.spd = spd[15:0];
    cmd.fb  = !hit;
    carrot_found = hit && !plast;
    return 1'b1;
  endfunction

  function automatic logic [19:0] rand_coord(input int unsigned span);
    int unsigned m;
    if ($urandom_range(15) == 0) return 20'($urandom);
    m = $urandom_range(span, 0);
    return $urandom_range(1) ? 20'(-m) : 20'(m);
  endfunction

  task automatic send_point(input logic [19:0] x, input logic [19:0] y, input logic last,
                            input bit known, input steer_res_t known_res);
    steer_res_t cmd;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    points_sent++;
    if (last) paths_sent++;
    if (next_carrot(x, y, last, cmd)) carrot_q.push_back(known ? known_res : cmd);
  endtask

  // Holds the stream until every carrot has come out and the scan is idle.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (carrot_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [22:0] wdata);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wdata;
    @(posedge clk);
    case (idx)
      CFG_LOOKAHEAD:   la_dist   = wdata[18:0];
      CFG_DESIRED:     v_desired = wdata[15:0];
      CFG_THRESHOLD:   k_thresh  = wdata;
      CFG_SPEED_FLOOR: v_min     = wdata[15:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : carrot_check
    steer_res_t act, want;
    if (!rst && m_tvalid && m_tready) begin
      act = {m_tdata[19:0], m_tdata[39:20], m_tdata[63:40], m_tdata[79:64], m_tuser};
      if (carrot_q.size() == 0) begin
        $display("%0t: carrot result with none expected: x=%0d y=%0d", $realtime,
                 $signed(act.cx), $signed(act.cy));
        fail_count++;
      end else begin
        want = carrot_q.pop_front();
        carrots_seen++;
        if (act.fb) fallbacks++;
        if (act !== want) begin
          $display("%0t: carrot mismatch: expected x=%0d y=%0d k=%0d v=%0d fb=%0b",
                   $realtime, $signed(want.cx), $signed(want.cy), $signed(want.k),
                   want.spd, want.fb);
          $display("%0t:                   actual x=%0d y=%0d k=%0d v=%0d fb=%0b",
                   $realtime, $signed(act.cx), $signed(act.cy), $signed(act.k),
                   act.spd, act.fb);
          fail_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    #20_000_000;
    $display("pure_pursuit_steering_command test failed");
    $finish;
  end

  initial begin
    int unsigned span, nl, nd, nt, nm;
    int scanned, plen, phase, i;
    bit noise;
    logic [19:0] x, y;
    logic last;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[r].idx, dir_tab[r].wdata);
        settings++;
      end else begin
        send_point(dir_tab[r].x, dir_tab[r].y, dir_tab[r].last,
                   dir_tab[r].kind == ROW_KNOWN, dir_tab[r].res);
      end
    end

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase / 3)
        0: begin tx_idle_pct = 6;  rx_stall_pct = 60; end
        1: begin tx_idle_pct = 60; rx_stall_pct = 6;  end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      settle();
      case (phase)
        0: begin nl = 4096; nd = 2048; nt = 0; nm = 0; end
        1: begin nl = 0; nd = 0; nt = 1; nm = 65535; end
        2: begin nl = 524287; nd = 65535; nt = 8388607; nm = 0; end
        default: begin
          case ($urandom_range(3))
            0: nl = $urandom_range(4096, 0);
            1: nl = $urandom_range(65536, 4096);
            2: nl = $urandom_range(524287, 65536);
            default: nl = $urandom_range(524287, 0);
          endcase
          nd = $urandom_range(65535, 0);
          if ($urandom_range(3) == 0) nt = 0;
          else if ($urandom_range(1)) nt = $urandom_range(65536, 1);
          else nt = $urandom_range(8388607, 1);
          nm = $urandom_range(65535, 0);
        end
      endcase
      write_reg(CFG_LOOKAHEAD, 23'(nl));
      write_reg(CFG_DESIRED, 23'(nd));
      write_reg(CFG_THRESHOLD, 23'(nt));
      write_reg(CFG_SPEED_FLOOR, 23'(nm));
      settings++;
      span = (2 * nl + 64 > 524287) ? 524287 : 2 * nl + 64;

      scanned = 0;
      while (scanned < ITEMS_PER_PHASE) begin
        plen  = $urandom_range(8, 1);
        noise = ($urandom_range(9) == 0);
        for (i = 0; i < plen; i++) begin
          // Clean paths move outward so the carrot tends to fall mid-path.
          if (noise) begin
            x    = 20'($urandom);
            y    = 20'($urandom);
            last = 1'($urandom_range(1));
          end else begin
            x    = rand_coord(span * (i + 1) / plen);
            y    = rand_coord(span * (i + 1) / plen);
            last = (i == plen - 1);
          end
          scanned++;
          send_point(x, y, last, 1'b0, '0);
        end
        if ($urandom_range(149) == 0) settle();
      end
    end

    s_tvalid <= 1'b0;
    while (carrot_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Run covered %0d points in %0d paths under %0d register settings.",
             points_sent, paths_sent, settings);
    $display("Checked %0d carrots: %0d by fallback, %0d with reduced speed.",
             carrots_seen, fallbacks, slowed);
    if (fail_count == 0) begin
      $display("pure_pursuit_steering_command test passed");
    end else begin
      $display("pure_pursuit_steering_command test failed");
    end
    $finish;
  end

endmodule

[files.f]
design/pp_steer_pkg.sv
design/pure_pursuit_steering_command.sv
dv/tb_pure_pursuit_steering_command.sv
